FILE: rtl/mmad_pkg.sv
// Shared types and constants for the min/max/average decimator.
// Used by every module of the block; depends on nothing.
package mmad_pkg;

  // Field and state widths
  localparam int unsigned SampleWidth   = 32;
  localparam int unsigned TimeWidth     = 63;
  localparam int unsigned SumWidth      = 48;
  localparam int unsigned CountWidth    = 16;
  localparam int unsigned RingWidth     = 13;
  localparam int unsigned SlotWidth     = 12;
  localparam int unsigned CfgDataWidth  = 16;
  localparam int unsigned CfgIndexWidth = 2;

  // Largest ring length the slot counter supports
  localparam int unsigned MaxPoints = 4096;

  // Configuration register indexes
  localparam logic [CfgIndexWidth-1:0] CfgSamplesPerPoint = CfgIndexWidth'(0);
  localparam logic [CfgIndexWidth-1:0] CfgPointsInUse     = CfgIndexWidth'(1);

  // Configuration reset values
  localparam logic [CountWidth-1:0] SppReset = CountWidth'(1);
  localparam logic [RingWidth-1:0]  PtsReset = RingWidth'(MaxPoints);

  // Extremes of the sample range, used as empty-block min/max
  localparam logic signed [SampleWidth-1:0] SampleMax = {1'b0, {(SampleWidth-1){1'b1}}};
  localparam logic signed [SampleWidth-1:0] SampleMin = {1'b1, {(SampleWidth-1){1'b0}}};

  typedef struct packed {
    logic signed [SampleWidth-1:0] sample;
    logic [TimeWidth-1:0]          timestamp;
  } in_word_t;

  typedef struct packed {
    logic signed [SampleWidth-1:0] average;
    logic signed [SampleWidth-1:0] minimum;
    logic signed [SampleWidth-1:0] maximum;
    logic [TimeWidth-1:0]          start_time;
    logic [SlotWidth-1:0]          slot;
    logic [RingWidth-1:0]          filled_count;
  } out_word_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;     // take the input word into the running stats
    logic div_start;  // block completes with this word: snapshot and divide
    logic load_out;   // move the finished point into the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic block_done;  // the next accepted word completes a block
    logic div_done;    // quotient is ready
  } dp_status_t;

endpackage

FILE: rtl/mmad_div.sv
// Restoring divider, one quotient bit per cycle, for the block average.
// Depends on mmad_pkg for widths.
module mmad_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [mmad_pkg::SumWidth-1:0]   dividend_i,
  input  logic [mmad_pkg::CountWidth-1:0] divisor_i,
  output logic [mmad_pkg::SumWidth-1:0]   quotient_o,
  output logic                            done_o
);
  import mmad_pkg::*;

  localparam int unsigned StepWidth = $clog2(SumWidth);
  localparam logic [StepWidth-1:0] LastStep = StepWidth'(SumWidth - 1);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [StepWidth-1:0]  step_q, step_d;
  logic [SumWidth-1:0]   quo_q, quo_d;
  logic [CountWidth-1:0] rem_q, rem_d;
  logic [CountWidth-1:0] dvs_q, dvs_d;
  logic [CountWidth:0]   rem_shift;
  logic                  fits;

  // Shift in the next dividend bit and try a subtract
  assign rem_shift = {rem_q, quo_q[SumWidth-1]};
  assign fits      = rem_shift >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[SumWidth-2:0], fits};
      rem_d = fits ? CountWidth'(rem_shift - {1'b0, dvs_q}) : rem_shift[CountWidth-1:0];
      step_d = step_q + StepWidth'(1);
      if (step_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

FILE: rtl/mmad_dp.sv
// Datapath: running sum/min/max, block start time, ring slot and fill count,
// average divider and the output register. Depends on mmad_pkg and mmad_div.
module mmad_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  mmad_pkg::ctrl_cmd_t             cmd_i,
  output mmad_pkg::dp_status_t            status_o,
  input  mmad_pkg::in_word_t              in_word_i,
  input  logic [mmad_pkg::CountWidth-1:0] spp_i,
  input  logic [mmad_pkg::RingWidth-1:0]  pts_i,
  output mmad_pkg::out_word_t             out_word_o
);
  import mmad_pkg::*;

  // Running block state
  logic signed [SumWidth-1:0]    sum_q;
  logic signed [SampleWidth-1:0] min_q, max_q;
  logic [CountWidth-1:0]         cnt_q;
  logic [TimeWidth-1:0]          start_q;
  logic [SlotWidth-1:0]          wslot_q;
  logic [RingWidth-1:0]          filled_q;

  // Snapshot of a completed block while the average is divided
  logic signed [SampleWidth-1:0] res_min_q, res_max_q;
  logic [TimeWidth-1:0]          res_start_q;
  logic [SlotWidth-1:0]          res_slot_q;
  logic [RingWidth-1:0]          res_fill_q;
  logic                          res_neg_q;
  out_word_t                     out_q;

  logic [CountWidth-1:0]         len_eff;
  logic [RingWidth-1:0]          ring_eff;
  logic [CountWidth:0]           cnt_inc;
  logic                          block_done;
  logic signed [SumWidth-1:0]    sample_ext, sum_new;
  logic signed [SampleWidth-1:0] min_new, max_new;
  logic [TimeWidth-1:0]          start_new;
  logic [RingWidth-1:0]          slot_cur, slot_inc, slot_next;
  logic [RingWidth:0]            fill_inc;
  logic [RingWidth-1:0]          fill_next;
  logic [SumWidth-1:0]           sum_mag;
  logic [SumWidth-1:0]           quotient, avg_full;
  logic                          div_done;

  // Clamp the configuration to usable values
  assign len_eff = (spp_i == '0) ? CountWidth'(1) : spp_i;
  always_comb begin
    if (pts_i == '0) begin
      ring_eff = RingWidth'(1);
    end else if (pts_i > RingWidth'(MaxPoints)) begin
      ring_eff = RingWidth'(MaxPoints);
    end else begin
      ring_eff = pts_i;
    end
  end

  // Block completes once the count reaches the length
  assign cnt_inc    = {1'b0, cnt_q} + (CountWidth+1)'(1);
  assign block_done = cnt_inc >= {1'b0, len_eff};

  // Fold the incoming sample into the running stats
  assign sample_ext = {{(SumWidth-SampleWidth){in_word_i.sample[SampleWidth-1]}},
                       in_word_i.sample};
  assign sum_new    = sum_q + sample_ext;
  assign min_new    = (in_word_i.sample < min_q) ? in_word_i.sample : min_q;
  assign max_new    = (in_word_i.sample > max_q) ? in_word_i.sample : max_q;
  assign start_new  = (cnt_q == '0) ? in_word_i.timestamp : start_q;
  assign sum_mag    = sum_new[SumWidth-1] ? SumWidth'(-sum_new) : SumWidth'(sum_new);

  // Ring slot for this point and the one after; restart at zero past a shrunk ring
  assign slot_cur  = ({1'b0, wslot_q} >= ring_eff) ? '0 : {1'b0, wslot_q};
  assign slot_inc  = slot_cur + RingWidth'(1);
  assign slot_next = (slot_inc >= ring_eff) ? '0 : slot_inc;
  assign fill_inc  = {1'b0, filled_q} + (RingWidth+1)'(1);
  assign fill_next = (fill_inc > {1'b0, ring_eff}) ? ring_eff : fill_inc[RingWidth-1:0];

  // Running state: update on accept, clear when the block completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q    <= '0;
      min_q    <= SampleMax;
      max_q    <= SampleMin;
      cnt_q    <= '0;
      start_q  <= '0;
      wslot_q  <= '0;
      filled_q <= '0;
    end else if (cmd_i.div_start) begin
      sum_q    <= '0;
      min_q    <= SampleMax;
      max_q    <= SampleMin;
      cnt_q    <= '0;
      start_q  <= start_new;
      wslot_q  <= slot_next[SlotWidth-1:0];
      filled_q <= fill_next;
    end else if (cmd_i.accept) begin
      sum_q   <= sum_new;
      min_q   <= min_new;
      max_q   <= max_new;
      cnt_q   <= cnt_inc[CountWidth-1:0];
      start_q <= start_new;
    end
  end

  // Hold the completed block's fields during the division
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      res_min_q   <= min_new;
      res_max_q   <= max_new;
      res_start_q <= start_new;
      res_slot_q  <= slot_cur[SlotWidth-1:0];
      res_fill_q  <= fill_next;
      res_neg_q   <= sum_new[SumWidth-1];
    end
  end

  mmad_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (sum_mag),
    .divisor_i  (cnt_inc[CountWidth-1:0]),
    .quotient_o (quotient),
    .done_o     (div_done)
  );

  // Restore the sign: truncation toward zero
  assign avg_full = res_neg_q ? SumWidth'(-quotient) : quotient;

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.average      <= avg_full[SampleWidth-1:0];
      out_q.minimum      <= res_min_q;
      out_q.maximum      <= res_max_q;
      out_q.start_time   <= res_start_q;
      out_q.slot         <= res_slot_q;
      out_q.filled_count <= res_fill_q;
    end
  end

  assign out_word_o          = out_q;
  assign status_o.block_done = block_done;
  assign status_o.div_done   = div_done;

endmodule

FILE: rtl/mmad_ctrl.sv
// Controller: input and output handshakes and the accumulate/divide sequence.
// Depends on mmad_pkg for the command and status structs.
module mmad_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  mmad_pkg::dp_status_t status_i,
  output mmad_pkg::ctrl_cmd_t  cmd_o
);
  import mmad_pkg::*;

  localparam logic [1:0] StAcc  = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StHold = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       in_acc;
  logic       out_free;

  assign in_ready_o = (state_q == StAcc);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // Sequence: accumulate, divide on a full block, then hand off the point
  always_comb begin
    state_d         = state_q;
    cmd_o.accept    = in_acc;
    cmd_o.div_start = 1'b0;
    cmd_o.load_out  = 1'b0;
    case (state_q)
      StAcc: begin
        if (in_acc && status_i.block_done) begin
          cmd_o.div_start = 1'b1;
          state_d         = StDiv;
        end
      end
      StDiv: begin
        if (status_i.div_done) begin
          if (out_free) begin
            cmd_o.load_out = 1'b1;
            state_d        = StAcc;
          end else begin
            state_d = StHold;
          end
        end
      end
      StHold: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = StAcc;
        end
      end
      default: begin
        state_d = StAcc;
      end
    endcase
  end

  // Output valid: set on load, drop when the word is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StAcc;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/min_max_avg_decimator_top.sv
// Min/max/average decimator top level: configuration registers, controller, datapath.
// A word that does not complete a block is only accumulated; a completing word starts a
// one-bit-per-cycle divide of the block sum, and its point moves to the output register
// once the divide is done and that register is free. Input is held off until then.
// The output register lets a point wait while the next block accumulates.
// Reset (async, active low) clears the running stats, ring position and valids.
module min_max_avg_decimator_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  mmad_pkg::in_word_t                 in_word_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output mmad_pkg::out_word_t                out_word_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [mmad_pkg::CfgIndexWidth-1:0] cfg_index_i,
  input  logic [mmad_pkg::CfgDataWidth-1:0]  cfg_data_i
);
  import mmad_pkg::*;

  logic [CountWidth-1:0] spp_q;
  logic [RingWidth-1:0]  pts_q;
  ctrl_cmd_t             cmd;
  dp_status_t            status;

  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spp_q <= SppReset;
      pts_q <= PtsReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgSamplesPerPoint: spp_q <= cfg_data_i[CountWidth-1:0];
        CfgPointsInUse:     pts_q <= cfg_data_i[RingWidth-1:0];
        default: ;
      endcase
    end
  end

  mmad_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mmad_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_word_i  (in_word_i),
    .spp_i      (spp_q),
    .pts_i      (pts_q),
    .out_word_o (out_word_o)
  );

endmodule

FILE: rtl/mmad_checker.sv
// Port-level checks for the decimator output channel, bound to the top level.
// Depends on mmad_pkg for the output word type.
module mmad_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input mmad_pkg::out_word_t out_word_o
);
  import mmad_pkg::*;

  // Hold a stalled point
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("output word dropped or changed while stalled");

  // A point always counts itself in the ring
  a_fill_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.filled_count != '0)
    else $error("point shows an empty ring");

  // The average lies between the block extremes
  a_avg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.minimum <= out_word_o.average) &&
                    (out_word_o.average <= out_word_o.maximum))
    else $error("average outside block min/max");

  // The slot of a point is inside the filled part of the ring
  a_slot_filled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> {1'b0, out_word_o.slot} < out_word_o.filled_count)
    else $error("slot beyond filled count");

endmodule

bind min_max_avg_decimator_top mmad_checker u_mmad_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_o  (out_word_o)
);
